// ----- sv/qnr_pkg.sv -----
`timescale 1ns / 1ps
package qnr_pkg;
	localparam int NPORTS = 5;
	localparam logic [2:0] UP_PORT = 3'd4;

	typedef enum logic [1:0] {
		KIND_ACCEPT  = 2'd0,
		KIND_REJECT  = 2'd1,
		KIND_FORWARD = 2'd2,
		KIND_DROP    = 2'd3
	} kind_t;

	localparam logic [2:0] REG_BASE = 3'd0;
	localparam logic [2:0] REG_MASK = 3'd1;
	localparam logic [2:0] REG_LOG2 = 3'd2;
	localparam logic [2:0] REG_PARENT = 3'd3;
	localparam logic [2:0] REG_LAT = 3'd4;
	localparam logic [2:0] REG_BUSY = 3'd5;

	// Controller to datapath commands.
	typedef struct packed {
		logic       arrive;    // handle the held item as an arrival
		logic       free;      // release expired outboxes
		logic       try_en;    // try one inbox
		logic [2:0] try_port;  // which inbox
		logic       use_rr;    // the try is the round-robin one
		logic       advance;   // advance the time counter
	} qnr_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic       res_full;  // the result register holds a result not yet taken
	} qnr_sts_t;
endpackage

// ----- sv/qnr_ctrl.sv -----
`timescale 1ns / 1ps
module qnr_ctrl import qnr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_op,
	output logic     in_ready,
	input  logic     out_empty,
	input  qnr_sts_t sts,
	output qnr_cmd_t cmd
);
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_FREE = 4'b0010,
		S_TRY  = 4'b0100,
		S_WAIT = 4'b1000
	} state_t;

	state_t     state_q;
	logic [2:0] step_q;
	logic       res_free;

	// A step may produce a result only when the datapath result register is empty.
	// A new item waits until every result of the previous one has been taken.
	assign res_free = !sts.res_full;
	assign in_ready = (state_q == S_IDLE) && res_free && out_empty;

	always_comb begin
		cmd = '0;
		cmd.arrive = in_valid && in_ready && in_op;
		cmd.free = (state_q == S_FREE);
		cmd.try_en = (state_q == S_TRY) && res_free;
		cmd.use_rr = (step_q == 3'd0);
		cmd.try_port = step_q - 3'd1;
		cmd.advance = cmd.try_en && (step_q == 3'd5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready && !in_op) begin
						state_q <= S_FREE;
					end
				end
				S_FREE: begin
					step_q <= '0;
					state_q <= S_TRY;
				end
				S_TRY: begin
					if (res_free) begin
						if (step_q == 3'd5) begin
							state_q <= S_WAIT;
						end else begin
							step_q <= step_q + 3'd1;
						end
					end
				end
				S_WAIT: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- sv/qnr_dp.sv -----
`timescale 1ns / 1ps
module qnr_dp import qnr_pkg::*; #(
	parameter int ADDR_WIDTH = 16,
	parameter int TIME_WIDTH = 32,
	parameter int LEN_WIDTH = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  qnr_cmd_t              cmd,
	input  logic [2:0]            in_port,
	input  logic [ADDR_WIDTH-1:0] in_dst,
	input  logic [ADDR_WIDTH-1:0] in_src,
	input  logic [LEN_WIDTH-1:0]  in_words,
	input  logic [15:0]           subnet_base,
	input  logic [15:0]           subnet_mask,
	input  logic [4:0]            subnet_size_log2,
	input  logic                  has_parent,
	input  logic [3:0]            forward_latency,
	input  logic [3:0]            busy_time,
	input  logic                  res_take,
	output logic                  res_valid,
	output logic [1:0]            res_kind,
	output logic [2:0]            res_in,
	output logic [2:0]            res_out,
	output logic [ADDR_WIDTH-1:0] res_dst,
	output logic [ADDR_WIDTH-1:0] res_src,
	output logic [LEN_WIDTH-1:0]  res_words,
	output logic                  res_last,
	output qnr_sts_t              sts
);
	localparam int PW = 2 * ADDR_WIDTH + LEN_WIDTH;

	logic [PW-1:0]         pkt_q [NPORTS];
	logic [NPORTS-1:0]     full_q;
	logic [TIME_WIDTH-1:0] ready_q [NPORTS];
	logic [NPORTS-1:0]     busy_q;
	logic [TIME_WIDTH-1:0] free_q [NPORTS];
	logic [2:0]            rr_q;
	logic [TIME_WIDTH-1:0] now_q;

	logic [2:0]            tp;
	logic                  tp_ok;
	logic [PW-1:0]         tpkt;
	logic [ADDR_WIDTH-1:0] tdst;
	logic [2:0]            dp;
	logic                  ready_ok;
	logic                  go;
	logic                  drop;
	logic [ADDR_WIDTH-1:0] base_x, mask_x, port_bits;
	logic [4:0]            lg;
	logic [4:0]            sh;

	assign tp = cmd.use_rr ? rr_q : cmd.try_port;
	assign tp_ok = (tp < 3'(NPORTS)) && full_q[tp];
	assign tpkt = pkt_q[tp];
	assign tdst = tpkt[ADDR_WIDTH-1:0];
	assign ready_ok = !(ready_q[tp] > now_q);

	always_comb begin
		base_x = '0;
		mask_x = '0;
		for (int b = 0; b < ADDR_WIDTH && b < 16; b++) begin
			base_x[b] = subnet_base[b];
			mask_x[b] = subnet_mask[b];
		end
		lg = subnet_size_log2;
		if (lg < 5'd2) lg = 5'd2;
		if (32'(lg) > ADDR_WIDTH) lg = 5'(ADDR_WIDTH);
		sh = lg - 5'd2;
		port_bits = ~((ADDR_WIDTH'(1) << sh) - ADDR_WIDTH'(1)) & ~mask_x;
		if ((tdst & mask_x) != base_x) begin
			dp = UP_PORT;
		end else begin
			dp = {1'b0, 2'((tdst & port_bits) >> sh)};
		end
	end

	assign go = cmd.try_en && tp_ok && ready_ok && !busy_q[dp];
	assign drop = go && (dp == UP_PORT) && !has_parent;

	assign sts.res_full = res_valid;

	always_ff @(posedge clk) begin
		if (cmd.arrive && in_port < 3'(NPORTS) && !full_q[in_port]) begin
			pkt_q[in_port] <= {in_words, in_src, in_dst};
		end
		if (cmd.arrive) begin
			res_kind <= (in_port >= 3'(NPORTS) || full_q[in_port]) ? KIND_REJECT : KIND_ACCEPT;
			res_in <= in_port;
			res_out <= '0;
			res_dst <= in_dst;
			res_src <= in_src;
			res_words <= in_words;
		end else if (go) begin
			res_kind <= drop ? KIND_DROP : KIND_FORWARD;
			res_in <= tp;
			res_out <= dp;
			res_dst <= tdst;
			res_src <= tpkt[2*ADDR_WIDTH-1:ADDR_WIDTH];
			res_words <= tpkt[PW-1:2*ADDR_WIDTH];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= '0;
			busy_q <= '0;
			rr_q <= '0;
			now_q <= '0;
			res_valid <= 1'b0;
			res_last <= 1'b0;
			for (int i = 0; i < NPORTS; i++) begin
				ready_q[i] <= '0;
				free_q[i] <= '0;
			end
		end else begin
			if (cmd.arrive) begin
				res_valid <= 1'b1;
				res_last <= 1'b1;
				if (in_port < 3'(NPORTS) && !full_q[in_port]) begin
					full_q[in_port] <= 1'b1;
					ready_q[in_port] <= now_q + TIME_WIDTH'(forward_latency);
				end
			end else if (go) begin
				res_valid <= 1'b1;
				res_last <= 1'b0;
			end else if (res_take) begin
				res_valid <= 1'b0;
			end
			if (cmd.free) begin
				for (int i = 0; i < NPORTS; i++) begin
					if (busy_q[i] && free_q[i] <= now_q) busy_q[i] <= 1'b0;
				end
			end
			if (go) begin
				full_q[tp] <= 1'b0;
				if (!drop) begin
					busy_q[dp] <= 1'b1;
					free_q[dp] <= now_q + TIME_WIDTH'(busy_time);
					rr_q <= (rr_q >= 3'd4) ? 3'd0 : rr_q + 3'd1;
				end
			end
			if (cmd.use_rr && cmd.try_en && rr_q >= 3'(NPORTS) && !go) begin
				rr_q <= '0;
			end
			if (cmd.advance) begin
				now_q <= now_q + TIME_WIDTH'(1);
			end
		end
	end
endmodule

// ----- sv/quadtree_noc_router_top.sv -----
`timescale 1ns / 1ps
// Five-port quadtree router: ports 0 to 3 face the children and port 4 the parent.
// An arrival transfer (op = 1) yields one accept or reject result. A tick
// transfer (op = 0) frees expired outboxes, then tries the round-robin inbox and
// inboxes 0 to 4 in order, one try per cycle through a shared route unit, and
// yields one result per forwarded or dropped packet; last marks the final one.
// A tick with nothing to report yields no result. After a tick is accepted the
// block passes through a free step, six tries and a finish step; each forwarded
// or dropped packet holds the next try back while its result leaves the datapath
// result register, and longer while the receiver stalls. An arrival result is
// registered in the datapath result register and then in the holding stage. A
// new input transfer is taken only once every result of the previous item has
// been taken. Tick results pass through a one-entry holding stage so that the
// final result of a tick is known before it is offered.
module quadtree_noc_router_top import qnr_pkg::*; #(
	parameter int ADDR_WIDTH = 16,
	parameter int TIME_WIDTH = 32,
	parameter int LEN_WIDTH = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// tdata: dst_addr, src_addr, pkt_words (low to high), zero filled
	input  logic [((2*ADDR_WIDTH+LEN_WIDTH+7)/8)*8-1:0] s_tdata,
	// tuser: op, src_port (low to high)
	input  logic [3:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// tdata: in_port, out_port, out_dst, out_src, out_words (low to high)
	output logic [((6+2*ADDR_WIDTH+LEN_WIDTH+7)/8)*8-1:0] m_tdata,
	// tuser: kind
	output logic [1:0] m_tuser,
	output logic m_tlast,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [4:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int OW = ((6+2*ADDR_WIDTH+LEN_WIDTH+7)/8)*8;

	logic [15:0] base_q, mask_q;
	logic [4:0]  log2_q;
	logic        par_q;
	logic [3:0]  lat_q, busy_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			mask_q <= '0;
			log2_q <= 5'd16;
			par_q <= 1'b0;
			lat_q <= 4'd4;
			busy_q <= 4'd4;
		end else if (psel && penable && pwrite) begin
			case (paddr[4:2])
				REG_BASE: base_q <= pwdata[15:0];
				REG_MASK: mask_q <= pwdata[15:0];
				REG_LOG2: log2_q <= pwdata[4:0];
				REG_PARENT: par_q <= pwdata[0];
				REG_LAT: lat_q <= pwdata[3:0];
				REG_BUSY: busy_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_BASE: prdata = {16'd0, base_q};
			REG_MASK: prdata = {16'd0, mask_q};
			REG_LOG2: prdata = {27'd0, log2_q};
			REG_PARENT: prdata = {31'd0, par_q};
			REG_LAT: prdata = {28'd0, lat_q};
			REG_BUSY: prdata = {28'd0, busy_q};
			default: prdata = '0;
		endcase
	end

	qnr_cmd_t cmd;
	qnr_sts_t sts;

	logic                  d_valid, r_last;
	logic [1:0]            r_kind;
	logic [2:0]            r_in, r_out;
	logic [ADDR_WIDTH-1:0] r_dst, r_src;
	logic [LEN_WIDTH-1:0]  r_words;

	// Holding stage: a tick result waits here until the next result of the same
	// tick sits in the datapath result register or the tick has finished its tries.
	logic          h_valid_q, h_last_q;
	logic [OW-1:0] h_data_q;
	logic [1:0]    h_kind_q;
	logic          h_take;
	logic          out_empty;
	logic          tick_q;

	assign m_tvalid = h_valid_q && (h_last_q || d_valid || !tick_q);
	assign m_tdata = h_data_q;
	assign m_tuser = h_kind_q;
	assign m_tlast = h_last_q || (!d_valid && !tick_q);
	assign h_take = d_valid && (!h_valid_q || (m_tvalid && m_tready));
	assign out_empty = !h_valid_q;

	// Set while a tick is trying inboxes; cleared at its last try.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= 1'b0;
		end else if (cmd.free) begin
			tick_q <= 1'b1;
		end else if (cmd.advance) begin
			tick_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_valid_q <= 1'b0;
			h_last_q <= 1'b0;
		end else begin
			if (h_take) begin
				h_valid_q <= 1'b1;
				h_last_q <= r_last;
			end else if (m_tvalid && m_tready) begin
				h_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (h_take) begin
			h_data_q <= OW'({r_words, r_src, r_dst, r_out, r_in});
			h_kind_q <= r_kind;
		end
	end

	qnr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_op(s_tuser[0]),
		.in_ready(s_tready), .out_empty(out_empty), .sts(sts), .cmd(cmd)
	);

	qnr_dp #(.ADDR_WIDTH(ADDR_WIDTH), .TIME_WIDTH(TIME_WIDTH), .LEN_WIDTH(LEN_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_port(s_tuser[3:1]),
		.in_dst(s_tdata[ADDR_WIDTH-1:0]),
		.in_src(s_tdata[2*ADDR_WIDTH-1:ADDR_WIDTH]),
		.in_words(s_tdata[2*ADDR_WIDTH+LEN_WIDTH-1:2*ADDR_WIDTH]),
		.subnet_base(base_q), .subnet_mask(mask_q), .subnet_size_log2(log2_q),
		.has_parent(par_q), .forward_latency(lat_q), .busy_time(busy_q),
		.res_take(h_take),
		.res_valid(d_valid), .res_kind(r_kind), .res_in(r_in), .res_out(r_out),
		.res_dst(r_dst), .res_src(r_src), .res_words(r_words), .res_last(r_last),
		.sts(sts)
	);
endmodule

// ----- sv/qnr_checker.sv -----
`timescale 1ns / 1ps
module qnr_checker import qnr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic m_tlast,
	input logic [1:0] m_tuser,
	input logic pready
);
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");
	a_acc_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_ACCEPT || m_tuser == KIND_REJECT) |-> m_tlast)
		else $error("arrival result without last");
	a_in_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> !m_tvalid)
		else $error("input taken while a result waits");
endmodule

bind quadtree_noc_router_top qnr_checker u_qnr_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tlast(m_tlast),
	.m_tuser(m_tuser), .pready(pready)
);

// ----- test/qnr_route_checker.sv -----
`timescale 1ns / 1ps
module qnr_route_checker import qnr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic s_tready,
	input  logic [39:0] s_tdata,
	input  logic [3:0] s_tuser,
	input  logic m_tvalid,
	input  logic m_tready,
	input  logic [47:0] m_tdata,
	input  logic [1:0] m_tuser,
	input  logic m_tlast,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [4:0] paddr,
	input  logic [31:0] pwdata,
	input  logic pready,
	output int mismatches,
	output int outstanding,
	output int forwards_seen,
	output int drops_seen
);
	typedef struct {
		kind_t       kind;
		logic [2:0]  in_port;
		logic [2:0]  out_port;
		logic [15:0] dst;
		logic [15:0] src;
		logic [7:0]  words;
		logic        last;
	} route_result_t;

	route_result_t expected_results[$];

	// Router configuration as the block should hold it.
	logic [15:0] cfg_base, cfg_mask;
	logic [4:0]  cfg_log2;
	logic        cfg_parent;
	logic [3:0]  cfg_lat, cfg_busy;

	// Router state.
	logic [15:0] inbox_dst[NPORTS], inbox_src[NPORTS];
	logic [7:0]  inbox_words[NPORTS];
	bit          inbox_held[NPORTS];
	logic [31:0] inbox_ready_at[NPORTS];
	bit          outbox_blocked[NPORTS];
	logic [31:0] outbox_free_at[NPORTS];
	int          rr_next;
	logic [31:0] tick_count;

	assign outstanding = expected_results.size();

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		mismatches++;
	endtask

	function automatic logic [2:0] pick_outbox(input logic [15:0] dst);
		int lg;
		logic [15:0] low_bits, port_bits;
		lg = cfg_log2;
		if (lg < 2) lg = 2;
		if (lg > 16) lg = 16;
		if ((dst & cfg_mask) != cfg_base) return UP_PORT;
		low_bits = (16'h1 << (lg - 2)) - 16'h1;
		port_bits = ~low_bits & ~cfg_mask;
		return 3'(((dst & port_bits) >> (lg - 2)) & 16'h3);
	endfunction

	function automatic route_result_t make_result(input kind_t k, input logic [2:0] ip,
			input logic [2:0] op, input logic [15:0] d, input logic [15:0] s,
			input logic [7:0] w);
		route_result_t r;
		r.kind = k;
		r.in_port = ip;
		r.out_port = op;
		r.dst = d;
		r.src = s;
		r.words = w;
		r.last = 1'b0;
		return r;
	endfunction

	// One inbox try of a tick; returns 1 when the packet was forwarded.
	task automatic try_inbox(input int p, inout int produced, output bit moved);
		logic [2:0] dp;
		moved = 0;
		if (!inbox_held[p] || inbox_ready_at[p] > tick_count) return;
		dp = pick_outbox(inbox_dst[p]);
		if (outbox_blocked[dp]) return;
		inbox_held[p] = 0;
		produced++;
		if (dp == UP_PORT && !cfg_parent) begin
			expected_results.push_back(make_result(KIND_DROP, 3'(p), UP_PORT,
				inbox_dst[p], inbox_src[p], inbox_words[p]));
			drops_seen++;
			return;
		end
		outbox_blocked[dp] = 1;
		outbox_free_at[dp] = tick_count + cfg_busy;
		expected_results.push_back(make_result(KIND_FORWARD, 3'(p), dp,
			inbox_dst[p], inbox_src[p], inbox_words[p]));
		forwards_seen++;
		moved = 1;
	endtask

	task automatic predict_tick();
		int produced;
		bit moved;
		route_result_t r;
		produced = 0;
		for (int i = 0; i < NPORTS; i++)
			if (outbox_blocked[i] && outbox_free_at[i] <= tick_count) outbox_blocked[i] = 0;
		if (rr_next >= NPORTS) rr_next = 0;
		try_inbox(rr_next, produced, moved);
		if (moved) rr_next = (rr_next + 1) % NPORTS;
		for (int i = 0; i < NPORTS; i++) begin
			try_inbox(i, produced, moved);
			if (moved) rr_next = (rr_next + 1) % NPORTS;
		end
		tick_count = tick_count + 32'd1;
		if (produced > 0) begin
			r = expected_results.pop_back();
			r.last = 1'b1;
			expected_results.push_back(r);
		end
	endtask

	task automatic predict_arrival(input logic [2:0] port, input logic [15:0] d,
			input logic [15:0] s, input logic [7:0] w);
		route_result_t r;
		if (port >= NPORTS || inbox_held[port]) begin
			r = make_result(KIND_REJECT, port, 3'd0, d, s, w);
		end else begin
			inbox_held[port] = 1;
			inbox_dst[port] = d;
			inbox_src[port] = s;
			inbox_words[port] = w;
			inbox_ready_at[port] = tick_count + cfg_lat;
			r = make_result(KIND_ACCEPT, port, 3'd0, d, s, w);
		end
		r.last = 1'b1;
		expected_results.push_back(r);
	endtask

	task automatic compare_result();
		route_result_t e;
		if (expected_results.size() == 0) begin
			report_mismatch($sformatf("unexpected result kind %0d port %0d",
				m_tuser, m_tdata[2:0]));
			return;
		end
		e = expected_results.pop_front();
		if (m_tuser != e.kind)
			report_mismatch($sformatf("kind %0d, expected %0d", m_tuser, e.kind));
		if (m_tdata[2:0] != e.in_port)
			report_mismatch($sformatf("in_port %0d, expected %0d", m_tdata[2:0], e.in_port));
		if (m_tdata[5:3] != e.out_port)
			report_mismatch($sformatf("out_port %0d, expected %0d", m_tdata[5:3], e.out_port));
		if (m_tdata[21:6] != e.dst)
			report_mismatch($sformatf("dst %h, expected %h", m_tdata[21:6], e.dst));
		if (m_tdata[37:22] != e.src)
			report_mismatch($sformatf("src %h, expected %h", m_tdata[37:22], e.src));
		if (m_tdata[45:38] != e.words)
			report_mismatch($sformatf("words %0d, expected %0d", m_tdata[45:38], e.words));
		if (m_tlast != e.last)
			report_mismatch($sformatf("last %0d, expected %0d", m_tlast, e.last));
	endtask

	initial begin
		mismatches = 0;
		forwards_seen = 0;
		drops_seen = 0;
		cfg_base = 16'h0;
		cfg_mask = 16'h0;
		cfg_log2 = 5'd16;
		cfg_parent = 1'b0;
		cfg_lat = 4'd4;
		cfg_busy = 4'd4;
		rr_next = 0;
		tick_count = 32'd0;
		for (int i = 0; i < NPORTS; i++) begin
			inbox_held[i] = 0;
			inbox_ready_at[i] = 32'd0;
			outbox_blocked[i] = 0;
			outbox_free_at[i] = 32'd0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_BASE:   cfg_base = pwdata[15:0];
					REG_MASK:   cfg_mask = pwdata[15:0];
					REG_LOG2:   cfg_log2 = pwdata[4:0];
					REG_PARENT: cfg_parent = pwdata[0];
					REG_LAT:    cfg_lat = pwdata[3:0];
					REG_BUSY:   cfg_busy = pwdata[3:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser[0]) predict_arrival(s_tuser[3:1], s_tdata[15:0], s_tdata[31:16],
					s_tdata[39:32]);
				else predict_tick();
			end
			if (m_tvalid && m_tready) compare_result();
		end
	end
endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
	import qnr_pkg::*;

	// A run that stands still this long has hung.
	localparam int STALL_LIMIT = 20000;
	// Cycles allowed for a tick that reports nothing to finish its pass.
	localparam int SETTLE_CYCLES = 40;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	// tdata: dst_addr, src_addr, pkt_words (low to high)
	logic [39:0] s_tdata;
	// tuser: op, src_port (low to high)
	logic [3:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	// tdata: in_port, out_port, out_dst, out_src, out_words (low to high), zero filled
	logic [47:0] m_tdata;
	// tuser: kind
	logic [1:0] m_tuser;
	logic m_tlast;
	logic psel, penable, pwrite, pready;
	logic [4:0] paddr;
	logic [31:0] pwdata, prdata;

	int mismatches, outstanding, forwards_seen, drops_seen;
	int send_idle_pct, recv_idle_pct;
	int items_sent, ticks_sent, arrivals_sent;
	int quiet_cycles;
	bit stall_request;
	int stall_left;

	// Current subnet, kept here only to aim random destinations into it.
	logic [15:0] aim_base, aim_mask;

	quadtree_noc_router_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	qnr_route_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.pready(pready),
		.mismatches(mismatches), .outstanding(outstanding),
		.forwards_seen(forwards_seen), .drops_seen(drops_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// The receiver takes results at random, or holds off entirely for a long
	// stretch when the stimulus asks for it, so the inboxes fill and the input stalls.
	always @(posedge clk) begin
		if (stall_request && stall_left == 0) begin
			stall_left <= 400;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// The watchdog counts cycles in which no transfer happens on any port.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: nothing moved for %0d cycles", STALL_LIMIT);
			$display("quadtree_noc_router_top regression: fail");
			$finish;
		end
	end

	// Offer one item and hold it until it is taken. The valid is lowered only
	// in an idle gap, so it never falls and rises within one step.
	task automatic send_item(input bit op, input logic [2:0] port, input logic [15:0] dst,
			input logic [15:0] src, input logic [7:0] words);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= {port, op};
		s_tdata <= {words, src, dst};
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if (op) arrivals_sent++;
		else ticks_sent++;
	endtask

	task automatic send_tick();
		send_item(1'b0, 3'($urandom_range(7)), 16'($urandom), 16'($urandom),
			8'($urandom));
	endtask

	task automatic send_arrival(input logic [2:0] port, input logic [15:0] dst);
		send_item(1'b1, port, dst, 16'($urandom), 8'($urandom));
	endtask

	// Let every expected result drain, then give a quiet tick time to finish.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic configure(input logic [15:0] base, input logic [15:0] mask,
			input logic [4:0] lg, input bit parent, input logic [3:0] lat,
			input logic [3:0] busy);
		reg_write(REG_BASE, {16'($urandom), base});
		reg_write(REG_MASK, {16'($urandom), mask});
		reg_write(REG_LOG2, {27'($urandom), lg});
		reg_write(REG_PARENT, {31'($urandom), parent});
		reg_write(REG_LAT, {28'($urandom), lat});
		reg_write(REG_BUSY, {28'($urandom), busy});
		aim_base = base;
		aim_mask = mask;
	endtask

	// Ticks and arrivals in equal share, arrivals mostly on real ports headed into
	// the subnet so packets get forwarded; now and then a bad port or a stray address.
	task automatic random_traffic(input int count);
		logic [15:0] dst;
		logic [2:0] port;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < 50) begin
				send_tick();
			end else begin
				port = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5))
					: 3'($urandom_range(4));
				dst = 16'($urandom);
				if ($urandom_range(99) < 60) dst = aim_base | (dst & ~aim_mask);
				send_arrival(port, dst);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		send_idle_pct = 20;
		recv_idle_pct = 80;
		items_sent = 0;
		ticks_sent = 0;
		arrivals_sent = 0;
		quiet_cycles = 0;
		stall_request = 0;
		stall_left = 0;
		aim_base = 16'h0;
		aim_mask = 16'h0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: a subnet with children on address bits 13:12 and a parent,
		// no forward latency and no busy time.
		configure(16'h4000, 16'hC000, 5'd14, 1'b1, 4'd0, 4'd0);
		send_arrival(3'd0, 16'h4000);
		send_arrival(3'd1, 16'h7FFF);
		send_arrival(3'd2, 16'h0000);
		send_arrival(3'd3, 16'hFFFF);
		send_item(1'b1, 3'd4, 16'h5000, 16'h0000, 8'h00);
		// A full inbox and ports above four are both rejected.
		send_item(1'b1, 3'd0, 16'hFFFF, 16'hFFFF, 8'hFF);
		send_arrival(3'd5, 16'h4000);
		send_arrival(3'd6, 16'h4000);
		send_arrival(3'd7, 16'h4000);
		// Two packets both aim at the parent, so the second waits for the outbox.
		repeat (4) send_tick();
		drain();

		// Root router: addresses outside the upper half are dropped, and a busy
		// time keeps outboxes blocked across ticks.
		configure(16'h8000, 16'h8000, 5'd15, 1'b0, 4'd2, 4'd3);
		send_arrival(3'd0, 16'h0123);
		send_arrival(3'd1, 16'hC000);
		send_arrival(3'd2, 16'hC001);
		send_arrival(3'd4, 16'h8000);
		repeat (8) send_tick();
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			send_idle_pct = (phase < 2) ? 20 : (phase < 4) ? 80 : 0;
			recv_idle_pct = (phase < 2) ? 80 : (phase < 4) ? 20 : 0;
			case (phase)
				0: configure(16'hFFFF, 16'hFFFF, 5'd2, 1'b1, 4'd15, 4'd15);
				1: configure(16'h0100, 16'hFF00, 5'd31, 1'b0, 4'd1, 4'd1);
				2: configure(16'h0000, 16'hF000, 5'd0, 1'b1, 4'd3, 4'd2);
				3: configure(16'h0000, 16'h0000, 5'd16, 1'b0, 4'd0, 4'd15);
				4: configure(16'h2000, 16'hE000, 5'd13, 1'b0, 4'd0, 4'd1);
				default: configure(16'($urandom), 16'($urandom), 5'($urandom_range(2, 16)),
					1'($urandom), 4'($urandom), 4'($urandom));
			endcase
			// One long receiver stall, requested for a single cycle.
			if (phase == 4) begin
				stall_request <= 1'b1;
				@(posedge clk);
				stall_request <= 1'b0;
			end
			random_traffic(65);
			drain();
		end

		$display("Sent %0d items (%0d arrivals, %0d ticks) over eight router settings.",
			items_sent, arrivals_sent, ticks_sent);
		$display("Saw %0d forwards and %0d drops; %0d mismatches.",
			forwards_seen, drops_seen, mismatches);
		if (mismatches == 0) begin
			$display("quadtree_noc_router_top regression: pass");
		end else begin
			$display("quadtree_noc_router_top regression: fail");
		end
		$finish;
	end
endmodule

// ----- quadtree_noc_router_top.f -----
sv/qnr_pkg.sv
sv/qnr_ctrl.sv
sv/qnr_dp.sv
sv/quadtree_noc_router_top.sv
sv/qnr_checker.sv
test/qnr_route_checker.sv
test/tb_top.sv
